>>> rtl/lzss_pkg.sv
package lzss_pkg;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_REF2  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_END  = 2'd2
  } cmd_kind_e;

  localparam int ByteW  = 8;
  localparam int DistW  = 12;
  localparam int NibW   = 4;
  localparam int FlagW  = 8;
  localparam int TokIdxW = 3;

  localparam logic [TokIdxW-1:0] LastTokIdx = 3'd7;
  localparam logic [NibW-1:0]    EndNib     = 4'h0;

  // queue depths
  localparam int CmdDepth = 2;
  localparam int ResDepth = 4;
  localparam int ResCntW  = $clog2(ResDepth + 1);

  // decoded token handed from parser to copy engine
  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] lit;
    logic [DistW-1:0] back_dist;   // distance minus one
    logic [NibW-1:0]  nib;         // length minus one
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             stream_end;
  } res_t;

  localparam int CmdW = $bits(cmd_t);
  localparam int ResW = $bits(res_t);

endpackage

>>> rtl/lzss_fifo.sv
module lzss_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [Width-1:0]             data_i,
  input  logic                         pop_i,
  output logic [Width-1:0]             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/lzss_front.sv
module lzss_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        in_byte_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output lzss_pkg::cmd_t    cmd_o
);
  import lzss_pkg::*;

  phase_e               phase_q, phase_d;
  logic [FlagW-1:0]     flags_q, flags_d;
  logic [TokIdxW-1:0]   idx_q, idx_d;
  logic [ByteW-1:0]     off_q, off_d;
  logic                 accept;
  logic [NibW-1:0]      nib;

  assign accept = push_i && !cmd_full_i;
  assign nib    = in_byte_i[NibW-1:0];

  // next state
  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    idx_d   = idx_q;
    off_d   = off_q;
    if (accept) begin
      unique case (phase_q)
        PH_TOKEN: begin
          if (flags_q[0]) begin
            off_d   = in_byte_i;
            phase_d = PH_REF2;
          end else begin
            flags_d = flags_q >> 1;
            idx_d   = idx_q + TokIdxW'(1);
            phase_d = (idx_q == LastTokIdx) ? PH_FLAG : PH_TOKEN;
          end
        end
        PH_REF2: begin
          if (nib == EndNib) begin
            phase_d = PH_FLAG;
            flags_d = '0;
            idx_d   = '0;
          end else begin
            flags_d = flags_q >> 1;
            idx_d   = idx_q + TokIdxW'(1);
            phase_d = (idx_q == LastTokIdx) ? PH_FLAG : PH_TOKEN;
          end
        end
        default: begin
          flags_d = in_byte_i;
          idx_d   = '0;
          phase_d = PH_TOKEN;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    cmd_push_o = 1'b0;
    cmd_o.kind = CMD_LIT;
    cmd_o.lit  = in_byte_i;
    cmd_o.back_dist = {off_q, in_byte_i[ByteW-1:NibW]};
    cmd_o.nib  = nib;
    unique case (phase_q)
      PH_TOKEN: begin
        cmd_push_o = accept && !flags_q[0];
      end
      PH_REF2: begin
        cmd_push_o = accept;
        cmd_o.kind = (nib == EndNib) ? CMD_END : CMD_COPY;
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      flags_q <= '0;
      idx_q   <= '0;
      off_q   <= '0;
    end else begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
    end
  end

endmodule

>>> rtl/lzss_back.sv
module lzss_back #(
  parameter int HistDepth = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lzss_pkg::cmd_t           cmd_i,
  input  logic                     cmd_empty_i,
  output logic                     cmd_pop_o,
  input  logic [lzss_pkg::ResCntW-1:0] res_cnt_i,
  output logic                     res_push_o,
  output lzss_pkg::res_t           res_o
);
  import lzss_pkg::*;

  localparam int AW = $clog2(HistDepth);
  localparam logic [AW-1:0] PtrMax = AW'(HistDepth - 1);

  logic [ByteW-1:0] ring_q [HistDepth];
  logic [ByteW-1:0] rdata_q;

  // issue stage
  logic [AW-1:0]    wp_q, wp_d, src_q, src_d;
  logic             wrap_q, wrap_d, active_q, active_d;
  logic [NibW-1:0]  rem_q, rem_d;

  // write-back stage
  logic             s2_valid_q, s2_lit_q, s2_end_q, s2_last_q, s2_ok_q;
  logic [ByteW-1:0] s2_byte_q;
  logic [AW-1:0]    s2_waddr_q;

  logic [ResCntW:0] occ;
  logic             space, issue, start, iss_lit, iss_end, iss_last, rd_ok;
  logic [AW-1:0]    rd_addr;
  logic             ram_we;
  logic [ByteW-1:0] wdata;

  // keep a slot for the byte already in flight
  assign occ   = {1'b0, res_cnt_i} + {{ResCntW{1'b0}}, s2_valid_q};
  assign space = occ < (ResCntW+1)'(ResDepth);
  assign issue = space && (active_q || !cmd_empty_i);
  assign start = issue && !active_q;
  assign cmd_pop_o = start;

  assign iss_lit  = !active_q && (cmd_i.kind == CMD_LIT);
  assign iss_end  = !active_q && (cmd_i.kind == CMD_END);
  assign iss_last = active_q ? (rem_q == NibW'(1)) : (cmd_i.kind != CMD_COPY);
  assign rd_addr  = active_q ? src_q : (wp_q - AW'(cmd_i.back_dist) - AW'(1));
  // slots not yet written since reset read as zero
  assign rd_ok    = wrap_q || (rd_addr < wp_q);

  always_comb begin
    wp_d     = wp_q;
    wrap_d   = wrap_q;
    active_d = active_q;
    src_d    = src_q;
    rem_d    = rem_q;
    if (issue) begin
      if (!iss_end) begin
        wp_d = wp_q + AW'(1);
        if (wp_q == PtrMax) begin
          wrap_d = 1'b1;
        end
      end
      src_d = rd_addr + AW'(1);
      if (active_q) begin
        rem_d    = rem_q - NibW'(1);
        active_d = (rem_q != NibW'(1));
      end else if (cmd_i.kind == CMD_COPY) begin
        rem_d    = cmd_i.nib;
        active_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      wrap_q     <= 1'b0;
      active_q   <= 1'b0;
      src_q      <= '0;
      rem_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      wrap_q     <= wrap_d;
      active_q   <= active_d;
      src_q      <= src_d;
      rem_q      <= rem_d;
      s2_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_lit_q   <= iss_lit;
      s2_end_q   <= iss_end;
      s2_last_q  <= iss_last;
      s2_ok_q    <= rd_ok;
      s2_byte_q  <= cmd_i.lit;
      s2_waddr_q <= wp_q;
    end
  end

  assign ram_we = s2_valid_q && !s2_end_q;
  assign wdata  = s2_lit_q ? s2_byte_q : (s2_ok_q ? rdata_q : '0);

  // history ring; write-first bypass covers distance one
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ring_q[s2_waddr_q] <= wdata;
    end
    if (issue) begin
      if (ram_we && (s2_waddr_q == rd_addr)) begin
        rdata_q <= wdata;
      end else begin
        rdata_q <= ring_q[rd_addr];
      end
    end
  end

  assign res_push_o       = s2_valid_q;
  assign res_o.data       = s2_end_q ? '0 : wdata;
  assign res_o.last       = s2_last_q;
  assign res_o.stream_end = s2_end_q;

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (res_cnt_i < ResCntW'(ResDepth)))
    else $error("result queue overrun");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_end_q) |-> s2_last_q)
    else $error("end marker not flagged last");

  a_copy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (rem_q != '0))
    else $error("copy running with no bytes left");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_q |=> wrap_q)
    else $error("ring wrap mark cleared");
`endif

endmodule

>>> rtl/lzss_stream_decompressor.sv
// LZSS stream decompressor, 12-bit distance, 4-bit length, 4096-byte history.
// Path: output bytes pass the token queue, write-back stage registers and result queue.
// Throughput: one input item per cycle in the parser while the token queue has room; the copy
//   engine emits one byte per cycle when the result queue has room, at most 16 per reference.
// Reset: asynchronous, active low; parser, queues and pointers clear at once, no clearing pass:
//   a write pointer plus wrap mark make never-written ring slots read as zero.
module lzss_stream_decompressor #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_end_o
);
  import lzss_pkg::*;

  // front to back: decoded tokens
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t               cmd_in, cmd_out;
  logic [CmdW-1:0]    cmd_raw;

  // back to result queue
  logic               res_push;
  res_t               res_in, res_out;
  logic [ResW-1:0]    res_raw;
  logic [ResCntW-1:0] res_cnt;

  assign full = cmd_full;

  // parser: flag bytes and first reference bytes stay here, tokens go on
  lzss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_byte_i  (in_byte_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // short token queue so parser and copy engine stall apart
  lzss_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_raw),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  assign cmd_out = cmd_t'(cmd_raw);

  // copy engine with the history ring
  lzss_back #(
    .HistDepth (HISTORY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_cnt_i   (res_cnt),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue decouples the consumer from the engine
  lzss_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_raw),
    .full_o  (),
    .empty_o (empty),
    .count_o (res_cnt)
  );

  assign res_out      = res_t'(res_raw);
  assign out_byte_o   = res_out.data;
  assign run_last_o   = res_out.last;
  assign stream_end_o = res_out.stream_end;

endmodule
